>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising edge out of reset
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define AST_IMPLY(label, clk, rst_n, ante, cons)
`define AST_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/fp7seg_pkg.sv
`default_nettype none

package fp7seg_pkg;

    typedef logic [7:0] t_seg;
    typedef logic [3:0] t_bcd;

    localparam t_seg SEG_BLANK = 8'h00;
    localparam t_seg SEG_MINUS = 8'h40;
    localparam t_seg SEG_DP    = 8'h80;
    localparam t_seg SEG_E     = 8'h79;
    localparam t_seg SEG_R     = 8'h50;

    // range limits on the magnitude
    localparam logic [31:0] POS_LIMIT = 32'd100000000;
    localparam logic [31:0] NEG_LIMIT = 32'd10000000;

    // floor(x / 10000) = (x * DIV10K_MUL) >> DIV10K_SHIFT, exact for x < 2**27
    localparam int          MAG_W        = 27;
    localparam logic [26:0] DIV10K_MUL   = 27'd109951163;
    localparam int          DIV10K_SHIFT = 40;
    localparam logic [13:0] TEN_K        = 14'd10000;

    // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT, exact for x < 2**14
    localparam logic [13:0] DIV100_MUL   = 14'd10486;
    localparam int          DIV100_SHIFT = 20;
    localparam logic [6:0]  HUNDRED      = 7'd100;

    // floor(x / 10) = (x * DIV10_MUL) >> DIV10_SHIFT, exact for x < 128
    localparam logic [7:0]  DIV10_MUL    = 8'd205;
    localparam int          DIV10_SHIFT  = 11;

    function automatic t_seg seg_of(input t_bcd d);
        t_seg s;
        unique case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fixed_point_to_seven_segment_top.sv
// channel   dir  tdata                                      tuser
// s_axis    in   [31:0] value_fixed                         -
// m_axis    out  [7:0] digit0 .. [31:24] digit3 segments     [0] out_of_range
//
// seven register stages: abs and range check, multiply by the reciprocal of
// 10000, integer/fraction split, divide by 100, remainder, tens/ones, format.
// o_m_tvalid is the valid bit of the format stage, so an output transaction
// follows once a value has passed every stage; one value is taken every cycle
// while the output side keeps up.
// synchronous active-low reset clears the stage valid bits only.
// each full stage holds while the one after it is full and stalled, so a stall at
// the output fills the empty stages before o_s_tready drops.
`default_nettype none

`include "assert_macros.svh"

module fixed_point_to_seven_segment_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] value_fixed
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // digit0, digit1, digit2, digit3 segments
    output logic             o_m_tuser    // [0] out_of_range
);
    import fp7seg_pkg::*;

    localparam int NSTG = 7;

    logic [NSTG:1]   r_vld;
    logic [NSTG+1:1] en;

    // stage 1
    logic             n1_neg, n1_oor;
    logic [31:0]      n1_mag32;
    logic             r1_neg, r1_oor;
    logic [MAG_W-1:0] r1_mag;
    // stage 2
    logic             r2_neg, r2_oor;
    logic [MAG_W-1:0] r2_mag;
    logic [2*MAG_W-1:0] r2_prod;
    // stage 3
    logic [13:0]      n3_ip, n3_fp;
    logic [27:0]      n3_ipk;
    logic             r3_neg, r3_oor;
    logic [13:0]      r3_ip, r3_fp;
    // stage 4
    logic [27:0]      n4_ip_prod, n4_fp_prod;
    logic             r4_neg, r4_oor;
    logic [13:0]      r4_ip, r4_fp;
    logic [6:0]       r4_ip_h, r4_fp_h;
    // stage 5
    logic             r5_neg, r5_oor;
    logic [6:0]       r5_ip_h, r5_fp_h, r5_ip_l, r5_fp_l;
    // stage 6, digits indexed by decimal weight (fdig[3] is tenths)
    t_bcd             n6_idig [4];
    t_bcd             n6_fdig [4];
    logic             r6_neg, r6_oor;
    t_bcd             r6_idig [4];
    t_bcd             r6_fdig [4];
    // stage 7
    logic [2:0]       n7_ilen, n7_slots, n7_nraw;
    logic [1:0]       n7_nfrac;
    logic             n7_nz;
    t_seg             n7_dig [4];
    logic [2:0]       k, j, fidx;
    t_seg             r_m_dig [4];
    logic             r_m_oor;

    // split a value below 100 into tens and ones
    function automatic logic [7:0] split_two(input logic [6:0] x);
        logic [14:0] p;
        t_bcd        t;
        t_bcd        o;
        p = {8'b0, x} * {7'b0, DIV10_MUL};
        t = p[DIV10_SHIFT +: 4];
        o = 4'(x - ({3'b0, t} * 7'd10));
        return {t, o};
    endfunction

    // per-stage enable: a stage loads when empty or when its successor moves
    always_comb begin
        en[NSTG+1] = i_m_tready;
        for (int s = NSTG; s >= 1; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign o_s_tready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_s_tvalid;
            end
            for (int s = 2; s <= NSTG; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // stage 1: magnitude and range check
    always_comb begin
        n1_neg   = i_s_tdata[31];
        n1_mag32 = n1_neg ? (32'd0 - i_s_tdata) : i_s_tdata;
        n1_oor   = n1_neg ? (n1_mag32 >= NEG_LIMIT) : (n1_mag32 >= POS_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_neg <= n1_neg;
            r1_oor <= n1_oor;
            r1_mag <= n1_mag32[MAG_W-1:0];
        end
    end

    // stage 2: reciprocal multiply for the integer part
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_neg  <= r1_neg;
            r2_oor  <= r1_oor;
            r2_mag  <= r1_mag;
            r2_prod <= {{MAG_W{1'b0}}, r1_mag} * {{MAG_W{1'b0}}, DIV10K_MUL};
        end
    end

    // stage 3: integer part and fraction remainder
    always_comb begin
        n3_ip  = r2_prod[DIV10K_SHIFT +: 14];
        n3_ipk = {14'b0, n3_ip} * {14'b0, TEN_K};
        n3_fp  = 14'({1'b0, r2_mag} - n3_ipk);
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_neg <= r2_neg;
            r3_oor <= r2_oor;
            r3_ip  <= n3_ip;
            r3_fp  <= n3_fp;
        end
    end

    // stage 4: upper digit pairs
    always_comb begin
        n4_ip_prod = {14'b0, r3_ip} * {14'b0, DIV100_MUL};
        n4_fp_prod = {14'b0, r3_fp} * {14'b0, DIV100_MUL};
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_neg  <= r3_neg;
            r4_oor  <= r3_oor;
            r4_ip   <= r3_ip;
            r4_fp   <= r3_fp;
            r4_ip_h <= n4_ip_prod[DIV100_SHIFT +: 7];
            r4_fp_h <= n4_fp_prod[DIV100_SHIFT +: 7];
        end
    end

    // stage 5: lower digit pairs
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_neg  <= r4_neg;
            r5_oor  <= r4_oor;
            r5_ip_h <= r4_ip_h;
            r5_fp_h <= r4_fp_h;
            r5_ip_l <= 7'(r4_ip - ({7'b0, r4_ip_h} * {7'b0, HUNDRED}));
            r5_fp_l <= 7'(r4_fp - ({7'b0, r4_fp_h} * {7'b0, HUNDRED}));
        end
    end

    // stage 6: single digits
    always_comb begin
        {n6_idig[3], n6_idig[2]} = split_two(r5_ip_h);
        {n6_idig[1], n6_idig[0]} = split_two(r5_ip_l);
        {n6_fdig[3], n6_fdig[2]} = split_two(r5_fp_h);
        {n6_fdig[1], n6_fdig[0]} = split_two(r5_fp_l);
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_neg  <= r5_neg;
            r6_oor  <= r5_oor;
            r6_idig <= n6_idig;
            r6_fdig <= n6_fdig;
        end
    end

    // stage 7: place the digits
    always_comb begin
        if (r6_idig[3] != 4'd0) begin
            n7_ilen = 3'd4;
        end else if (r6_idig[2] != 4'd0) begin
            n7_ilen = 3'd3;
        end else if (r6_idig[1] != 4'd0) begin
            n7_ilen = 3'd2;
        end else begin
            n7_ilen = 3'd1;
        end
        n7_slots = r6_neg ? 3'd3 : 3'd4;
        n7_nraw  = (n7_slots > n7_ilen) ? (n7_slots - n7_ilen) : 3'd0;
        case (n7_nraw)
            3'd1:    n7_nz = (r6_fdig[3] != 4'd0);
            3'd2:    n7_nz = ({r6_fdig[3], r6_fdig[2]} != 8'd0);
            3'd3:    n7_nz = ({r6_fdig[3], r6_fdig[2], r6_fdig[1]} != 12'd0);
            default: n7_nz = 1'b0;
        endcase
        // a fraction of zeros is dropped along with its point
        n7_nfrac = n7_nz ? n7_nraw[1:0] : 2'd0;

        k    = '0;
        j    = '0;
        fidx = '0;
        for (int p = 0; p < 4; p++) begin
            k    = 3'(3 - p);
            j    = k - {1'b0, n7_nfrac};
            fidx = k + 3'd4 - {1'b0, n7_nfrac};
            if (k < {1'b0, n7_nfrac}) begin
                n7_dig[p] = seg_of(r6_fdig[fidx[1:0]]);
            end else if (j < n7_ilen) begin
                n7_dig[p] = seg_of(r6_idig[j[1:0]]);
                if (j == 3'd0 && n7_nfrac != 2'd0) begin
                    n7_dig[p] = n7_dig[p] | SEG_DP;
                end
            end else if (j == n7_ilen && r6_neg) begin
                n7_dig[p] = SEG_MINUS;
            end else begin
                n7_dig[p] = SEG_BLANK;
            end
        end
        if (r6_oor) begin
            n7_dig[0] = SEG_BLANK;
            n7_dig[1] = SEG_E;
            n7_dig[2] = SEG_R;
            n7_dig[3] = SEG_R;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_m_dig <= n7_dig;
            r_m_oor <= r6_oor;
        end
    end

    assign o_m_tvalid = r_vld[NSTG];
    assign o_m_tdata  = {r_m_dig[3], r_m_dig[2], r_m_dig[1], r_m_dig[0]};
    assign o_m_tuser  = r_m_oor;

    // an empty output stage means every stage can move
    `AST_IMPLY(a_ready_when_out_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)
    // err pattern goes with the flag
    `AST_IMPLY(a_err_pattern, i_clk, i_rst_n, o_m_tvalid && o_m_tuser,
        (o_m_tdata == {SEG_R, SEG_R, SEG_E, SEG_BLANK}))
    // never more than one decimal point
    `AST_IMPLY(a_single_dp, i_clk, i_rst_n, o_m_tvalid,
        $onehot0({o_m_tdata[31], o_m_tdata[23], o_m_tdata[15], o_m_tdata[7]}))
    // an accepted transaction into a full, stalled pipe is impossible
    `AST_IMPLY(a_full_stall_blocks, i_clk, i_rst_n,
        (&r_vld) && !i_m_tready, !o_s_tready)
    // a stalled output transaction holds its data
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))

endmodule

`default_nettype wire

>>> tb/sv/fixed_point_to_seven_segment_top_tb.sv
module fixed_point_to_seven_segment_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fp7seg_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_DIRECTED  = 24;
    localparam int N_RANDOM    = 1000;
    localparam int N_PHASES    = 4;
    localparam int DRAIN_TAIL  = 16;

    localparam t_seg SEG_D0 = 8'h3F;
    localparam t_seg SEG_D9 = 8'h6F;

    typedef struct packed {
        t_seg digit0;
        t_seg digit1;
        t_seg digit2;
        t_seg digit3;
        logic out_of_range;
    } t_display;

    typedef struct {
        logic [31:0] value;
        bit          typed;
        t_display    show;
    } t_stim_row;

    typedef struct {
        logic [31:0] value;
        t_display    show;
    } t_pending;

    localparam t_display SHOW_ERR  = '{SEG_BLANK, SEG_E, SEG_R, SEG_R, 1'b1};
    localparam t_display SHOW_ZERO = '{SEG_BLANK, SEG_BLANK, SEG_BLANK, SEG_D0, 1'b0};
    localparam t_display SHOW_NEG0 = '{SEG_BLANK, SEG_BLANK, SEG_MINUS, SEG_D0, 1'b0};
    localparam t_display SHOW_9999 = '{SEG_D9, SEG_D9, SEG_D9, SEG_D9, 1'b0};
    localparam t_display SHOW_N999 = '{SEG_MINUS, SEG_D9, SEG_D9, SEG_D9, 1'b0};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int cycle_count  = 0;
    int mismatches   = 0;

    t_pending pending_shows[$];

    // rows with a typed display are checked against it, the rest use the predictor
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{32'd0,          1'b1, SHOW_ZERO},
        '{32'd100000000,  1'b1, SHOW_ERR},
        '{32'd99999999,   1'b1, SHOW_9999},
        '{-32'sd10000000, 1'b1, SHOW_ERR},
        '{-32'sd9999999,  1'b1, SHOW_N999},
        '{32'h7FFFFFFF,   1'b1, SHOW_ERR},
        '{32'h80000000,   1'b1, SHOW_ERR},
        '{-32'sd1,        1'b1, SHOW_NEG0},
        '{32'd31000,      1'b0, '0},
        '{-32'sd99,       1'b0, '0},
        '{32'd1,          1'b0, '0},
        '{32'd10,         1'b0, '0},
        '{32'd12345678,   1'b0, '0},
        '{32'd1234567,    1'b0, '0},
        '{-32'sd1234567,  1'b0, '0},
        '{-32'sd123456,   1'b0, '0},
        '{-32'sd12345,    1'b0, '0},
        '{32'd99990000,   1'b0, '0},
        '{32'd5,          1'b0, '0},
        '{-32'sd9999,     1'b0, '0},
        '{32'd10000,      1'b0, '0},
        '{32'd10500,      1'b0, '0},
        '{-32'sd5000,     1'b0, '0},
        '{32'd50000,      1'b0, '0}
    };

    fixed_point_to_seven_segment_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic t_seg digit_seg(input int d);
        t_seg s;
        case (d)
            0:       s = SEG_D0;
            1:       s = 8'h06;
            2:       s = 8'h5B;
            3:       s = 8'h4F;
            4:       s = 8'h66;
            5:       s = 8'h6D;
            6:       s = 8'h7D;
            7:       s = 8'h07;
            8:       s = 8'h7F;
            default: s = SEG_D9;
        endcase
        return s;
    endfunction

    function automatic t_display format_value(input logic [31:0] raw);
        t_seg        d [4];
        logic        neg;
        logic [31:0] mag;
        int          int_part;
        int          frac_part;
        int          int_len;
        int          nfrac;
        int          shown;
        int          slot;
        neg = raw[31];
        mag = neg ? (32'd0 - raw) : raw;
        if ((!neg && mag >= POS_LIMIT) || (neg && mag >= NEG_LIMIT)) begin
            return SHOW_ERR;
        end
        int_part  = int'(mag / 32'd10000);
        frac_part = int'(mag % 32'd10000);
        int_len   = (int_part < 10) ? 1 : (int_part < 100) ? 2 : (int_part < 1000) ? 3 : 4;
        nfrac     = (neg ? 3 : 4) - int_len;
        if (nfrac < 0)
            nfrac = 0;
        shown = (nfrac > 0) ? frac_part / (10 ** (4 - nfrac)) : 0;
        // all-zero fraction drops the digits and the point
        if (shown == 0)
            nfrac = 0;
        for (int i = 0; i < 4; i++)
            d[i] = SEG_BLANK;
        slot = 3;
        for (int i = 0; i < nfrac; i++) begin
            d[slot] = digit_seg(shown % 10);
            shown   = shown / 10;
            slot--;
        end
        for (int i = 0; i < int_len && slot >= 0; i++) begin
            d[slot] = digit_seg(int_part % 10);
            if (i == 0 && nfrac > 0)
                d[slot] = d[slot] | SEG_DP;
            int_part = int_part / 10;
            slot--;
        end
        if (neg && slot >= 0)
            d[slot] = SEG_MINUS;
        return '{d[0], d[1], d[2], d[3], 1'b0};
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] mag;
        logic        neg;
        neg = 1'($urandom_range(1));
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'd100000000 - 32'd20 + $urandom_range(40);
            2: return 32'd0 - (32'd10000000 - 32'd20 + $urandom_range(40));
            3: mag = $urandom_range(99999);
            // fractions with trailing zeros
            4: mag = $urandom_range(9999) * 10000 + $urandom_range(9) * (10 ** $urandom_range(3));
            5: mag = $urandom_range(9999999);
            default: mag = $urandom_range(99999999);
        endcase
        return neg ? (32'd0 - mag) : mag;
    endfunction

    task automatic send_value(input logic [31:0] v, input t_display want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge clk); while (!s_tready);
        pending_shows.push_back('{v, want});
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_shows.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // output transaction check
    always @(posedge clk) begin
        t_pending want;
        t_display got;
        if (rst_n && m_tvalid && m_tready) begin
            got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24], m_tuser};
            if (pending_shows.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result tdata %h tuser %b", m_tdata, m_tuser);
            end else begin
                want = pending_shows.pop_front();
                if (got.digit0 !== want.show.digit0 || got.digit1 !== want.show.digit1 ||
                    got.digit2 !== want.show.digit2 || got.digit3 !== want.show.digit3 ||
                    got.out_of_range !== want.show.out_of_range) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("value %0d: expected %h %h %h %h oor %b, got %h %h %h %h oor %b",
                                 $signed(want.value),
                                 want.show.digit0, want.show.digit1, want.show.digit2,
                                 want.show.digit3, want.show.out_of_range,
                                 got.digit0, got.digit1, got.digit2, got.digit3,
                                 got.out_of_range);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[fixed_point_to_seven_segment_top] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_value(directed_rows[i].value,
                       directed_rows[i].typed ? directed_rows[i].show
                                              : format_value(directed_rows[i].value));
        drain_results();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
                default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
            endcase
            for (int i = 0; i < N_RANDOM / N_PHASES; i++) begin
                logic [31:0] v;
                v = random_value();
                send_value(v, format_value(v));
            end
            // sender holds off until the pipeline is empty
            drain_results();
        end

        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatches == 0)
            $display("[fixed_point_to_seven_segment_top] OK");
        else
            $display("[fixed_point_to_seven_segment_top] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/fp7seg_pkg.sv
rtl/fixed_point_to_seven_segment_top.sv
tb/sv/fixed_point_to_seven_segment_top_tb.sv
